/* src/wmf_pkg.sv */
// Shared types and constants of the windowed mean filter.
package wmf_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_ACC,
		ST_RDIV,
		ST_FIN,
		ST_FDIV,
		ST_OUT
	} state_t;

	localparam logic [1:0] MODE_ARITH    = 2'd0;
	localparam logic [1:0] MODE_WEIGHTED = 2'd1;
	localparam logic [1:0] MODE_HARMONIC = 2'd2;
	localparam logic [1:0] MODE_EXP      = 2'd3;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_DIV0 = 2'd1;
	localparam logic [1:0] STAT_SAT  = 2'd2;

	localparam logic [1:0] CFG_MODE   = 2'd0;
	localparam logic [1:0] CFG_LENGTH = 2'd1;
	localparam logic [1:0] CFG_ALPHA  = 2'd2;

	localparam logic OP_PUSH  = 1'b0;
	localparam logic OP_WLOAD = 1'b1;

	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 9;
	localparam int MODE_BITS      = 2;
	localparam int LEN_BITS       = 7;
	localparam int ALPHA_BITS     = 9;
	localparam int WIDX_BITS      = 6;
	localparam int WVAL_BITS      = 8;
	localparam int STAT_BITS      = 2;
	localparam int RECIP_SHIFT    = 24;
	localparam int EXP_SHIFT      = 8;

	localparam logic [LEN_BITS-1:0]   LENGTH_RESET = 7'd40;
	localparam logic [ALPHA_BITS-1:0] ALPHA_RESET  = 9'd51;
	localparam logic [ALPHA_BITS-1:0] ALPHA_ONE    = 9'd256;
	localparam logic [WVAL_BITS-1:0]  WEIGHT_RESET = 8'd1;

endpackage

/* src/windowed_mean_filter_core.sv */
// Top level of the windowed mean filter.
// Usage:
//   Input channel (in_valid/in_stall) carries one word: opcode, sample,
//   weight_index, weight_value. A weight load or a push that does not yet
//   fill the window is taken while idle and gives no result.
//   A push with a full window walks the sample ring in memory, with a read
//   state and an accumulate state per sample. Arithmetic and weighted modes
//   then run one final division. Exponential mode needs no division.
//   Harmonic mode adds one reciprocal division per nonzero sample; all
//   divisions go through the shared serial divider.
//   Output channel (out_valid/out_stall) carries mean and status; the output
//   register holds a word while stalled and the next input word is still
//   taken while it waits.
//   Config port (cfg_valid/cfg_ready, always ready) writes mode,
//   window_length, alpha; write only while the block is idle.
//   Reset: config to defaults, ring empty, weight table reads as all ones
//   through per-entry valid bits; no clearing pass.
module windowed_mean_filter_core import wmf_pkg::*; #(
	parameter int WINDOW_MAX  = 64,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
	input  logic [CFG_DATA_BITS-1:0]      cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          opcode,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic [WIDX_BITS-1:0]          weight_index,
	input  logic [WVAL_BITS-1:0]          weight_value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] mean,
	output logic [STAT_BITS-1:0]          status
);

	localparam int IW   = $clog2(WINDOW_MAX);
	localparam int AW   = $clog2(WINDOW_MAX + 1);
	localparam int LW   = (AW > LEN_BITS) ? AW : LEN_BITS;
	localparam int BW   = IW + 2;
	localparam int SUMW = SAMPLE_BITS + WVAL_BITS + AW + 1;
	localparam int HW   = RECIP_SHIFT + AW + 2;
	localparam int DW   = (SUMW > HW) ? SUMW : HW;
	localparam int ACW  = DW + 1;
	localparam int EW   = SAMPLE_BITS + ALPHA_BITS + 2;
	localparam int XW   = SAMPLE_BITS + WVAL_BITS + 1;

	localparam logic [DW-1:0]  RECIP_NUM = DW'(1) << RECIP_SHIFT;
	localparam logic [ACW-1:0] SAT_HI    = (ACW'(1) << (SAMPLE_BITS - 1)) - ACW'(1);
	localparam logic [ACW-1:0] SAT_LO    = ~SAT_HI;
	localparam logic [EW-1:0]  EXP_ROUND = (EW'(1) << EXP_SHIFT) - EW'(1);

	state_t state_q, state_d;

	logic [MODE_BITS-1:0]  mode_q;
	logic [LEN_BITS-1:0]   wlen_q;
	logic [ALPHA_BITS-1:0] alpha_q;

	logic [IW-1:0]  wp_q, wp_next, rp_q, rp_next, k_q;
	logic [AW-1:0]  fill_q, fill_next, len_q, len_eff;
	logic [LW-1:0]  wlen_ext;
	logic [BW-1:0]  base_raw;
	logic [IW-1:0]  base;
	logic [ALPHA_BITS-1:0] alpha_eff;
	logic [WINDOW_MAX-1:0] wvalid_q;
	logic           wv_s1;
	logic           last, last_q, zero_q, xneg_q, fneg_q;

	logic in_accept, push, wload, start_ok, out_load;

	logic signed [ACW-1:0] acc_q, wsum_q;
	logic signed [SAMPLE_BITS-1:0] e_q, x, e_new;
	logic [SAMPLE_BITS-1:0] ring_rdata;
	logic [WVAL_BITS-1:0]   wram_rdata, w;
	logic signed [XW-1:0]   wx;
	logic signed [EW-1:0]   e_mix, e_div;
	logic signed [ACW-1:0]  xw, xmag, amag, qs, sat_in;
	logic [ALPHA_BITS:0]    one_minus_a;

	logic          div_start, div_done, fin_err;
	logic [DW-1:0] div_num, div_den, div_quo;
	logic [DW-1:0] fin_num, fin_den;
	logic          fin_neg;

	logic signed [SAMPLE_BITS-1:0] res_mean_q, out_mean_q, sat_val;
	logic [STAT_BITS-1:0]          res_stat_q, out_stat_q, sat_stat;
	logic                          out_valid_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_ARITH;
			wlen_q  <= LENGTH_RESET;
			alpha_q <= ALPHA_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MODE:   mode_q  <= cfg_data[MODE_BITS-1:0];
				CFG_LENGTH: wlen_q  <= cfg_data[LEN_BITS-1:0];
				CFG_ALPHA:  alpha_q <= cfg_data[ALPHA_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign wlen_ext  = LW'(wlen_q);
	assign len_eff   = (wlen_ext == '0) ? AW'(1) :
		(wlen_ext > LW'(WINDOW_MAX)) ? AW'(WINDOW_MAX) : AW'(wlen_ext);
	assign alpha_eff   = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
	assign one_minus_a = {1'b0, ALPHA_ONE} - {1'b0, alpha_eff};

	assign in_accept = in_valid && !in_stall;
	assign push      = in_accept && (opcode == OP_PUSH);
	assign wload     = in_accept && (opcode == OP_WLOAD) &&
		(32'(weight_index) < WINDOW_MAX);

	assign wp_next   = (wp_q == IW'(WINDOW_MAX - 1)) ? '0 : wp_q + 1'b1;
	assign fill_next = (fill_q == AW'(WINDOW_MAX)) ? fill_q : fill_q + 1'b1;
	assign start_ok  = fill_next >= len_eff;
	assign base_raw  = BW'(wp_next) + BW'(WINDOW_MAX) - BW'(len_eff);
	assign base      = (base_raw >= BW'(WINDOW_MAX)) ?
		IW'(base_raw - BW'(WINDOW_MAX)) : IW'(base_raw);
	assign rp_next   = (rp_q == IW'(WINDOW_MAX - 1)) ? '0 : rp_q + 1'b1;
	assign last      = (AW'(k_q) == len_q - 1'b1);

	wmf_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(WINDOW_MAX)) u_ring (
		.clk   (clk),
		.we    (push),
		.waddr (wp_q),
		.wdata (sample),
		.re    (state_q == ST_READ),
		.raddr (rp_q),
		.rdata (ring_rdata)
	);

	wmf_ram #(.WIDTH(WVAL_BITS), .DEPTH(WINDOW_MAX)) u_wtab (
		.clk   (clk),
		.we    (wload),
		.waddr (IW'(weight_index)),
		.wdata (weight_value),
		.re    (state_q == ST_READ),
		.raddr (k_q),
		.rdata (wram_rdata)
	);

	// datapath on the word read back from memory
	assign x     = signed'(ring_rdata);
	assign w     = wv_s1 ? wram_rdata : WEIGHT_RESET;
	assign wx    = XW'(x) * signed'(XW'({1'b0, w}));
	assign e_mix = EW'(e_q) * signed'(EW'(one_minus_a)) + signed'(EW'(alpha_eff)) * EW'(x);
	assign e_div = (e_mix < 0) ? ((e_mix + EXP_ROUND) >>> EXP_SHIFT) : (e_mix >>> EXP_SHIFT);
	assign e_new = e_div[SAMPLE_BITS-1:0];
	assign xw    = ACW'(x);
	assign xmag  = xw[ACW-1] ? -xw : xw;
	assign amag  = acc_q[ACW-1] ? -acc_q : acc_q;
	assign qs    = fneg_q ? -signed'(ACW'(div_quo)) : signed'(ACW'(div_quo));

	always_comb begin
		fin_num = amag[DW-1:0];
		fin_den = DW'(len_q);
		fin_neg = acc_q[ACW-1];
		fin_err = 1'b0;
		case (mode_q)
			MODE_ARITH: ;
			MODE_WEIGHTED: begin
				fin_den = wsum_q[DW-1:0];
				fin_err = (wsum_q == '0);
			end
			MODE_HARMONIC: begin
				fin_num = DW'(len_q) << RECIP_SHIFT;
				fin_den = amag[DW-1:0];
				fin_err = zero_q || (acc_q == '0);
			end
			default: fin_err = 1'b0;
		endcase
	end

	always_comb begin
		div_start = 1'b0;
		div_num   = fin_num;
		div_den   = fin_den;
		if (state_q == ST_ACC) begin
			div_start = (mode_q == MODE_HARMONIC) && (x != '0);
			div_num   = RECIP_NUM;
			div_den   = xmag[DW-1:0];
		end else if (state_q == ST_FIN) begin
			div_start = !fin_err && (mode_q != MODE_EXP);
		end
	end

	wmf_div #(.W(DW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign sat_in   = (state_q == ST_FDIV) ? qs : ACW'(e_q);
	assign sat_val  = (sat_in > signed'(SAT_HI)) ? SAMPLE_BITS'(SAT_HI) :
		(sat_in < signed'(SAT_LO)) ? SAMPLE_BITS'(SAT_LO) : sat_in[SAMPLE_BITS-1:0];
	assign sat_stat = ((sat_in > signed'(SAT_HI)) || (sat_in < signed'(SAT_LO))) ?
		STAT_SAT : STAT_OK;

	assign out_load = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (push && start_ok) state_d = ST_READ;
			ST_READ: state_d = ST_ACC;
			ST_ACC: begin
				if ((mode_q == MODE_HARMONIC) && (x != '0)) state_d = ST_RDIV;
				else if (last) state_d = ST_FIN;
				else state_d = ST_READ;
			end
			ST_RDIV: if (div_done) state_d = last_q ? ST_FIN : ST_READ;
			ST_FIN: state_d = (fin_err || (mode_q == MODE_EXP)) ? ST_OUT : ST_FDIV;
			ST_FDIV: if (div_done) state_d = ST_OUT;
			ST_OUT: if (out_load) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = (state_q != ST_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wp_q        <= '0;
			fill_q      <= '0;
			wvalid_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (push) begin
				wp_q   <= wp_next;
				fill_q <= fill_next;
			end
			if (wload) wvalid_q[IW'(weight_index)] <= 1'b1;
			if (state_q == ST_OUT && out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				acc_q  <= '0;
				wsum_q <= '0;
				e_q    <= '0;
				zero_q <= 1'b0;
				k_q    <= '0;
				rp_q   <= base;
				len_q  <= len_eff;
			end
			ST_READ: wv_s1 <= wvalid_q[k_q];
			ST_ACC: begin
				k_q    <= k_q + 1'b1;
				rp_q   <= rp_next;
				last_q <= last;
				xneg_q <= x[SAMPLE_BITS-1];
				case (mode_q)
					MODE_ARITH: acc_q <= acc_q + xw;
					MODE_WEIGHTED: begin
						acc_q  <= acc_q + ACW'(wx);
						wsum_q <= wsum_q + signed'(ACW'(w));
					end
					MODE_HARMONIC: if (x == '0) zero_q <= 1'b1;
					default: e_q <= e_new;
				endcase
			end
			ST_RDIV: begin
				if (div_done) begin
					acc_q <= xneg_q ? acc_q - signed'(ACW'(div_quo)) :
						acc_q + signed'(ACW'(div_quo));
				end
			end
			ST_FIN: begin
				fneg_q <= fin_neg;
				if (fin_err) begin
					res_mean_q <= '0;
					res_stat_q <= STAT_DIV0;
				end else begin
					res_mean_q <= sat_val;
					res_stat_q <= sat_stat;
				end
			end
			ST_FDIV: begin
				if (div_done) begin
					res_mean_q <= sat_val;
					res_stat_q <= sat_stat;
				end
			end
			ST_OUT: begin
				if (out_load) begin
					out_mean_q <= res_mean_q;
					out_stat_q <= res_stat_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign mean      = out_mean_q;
	assign status    = out_stat_q;

endmodule

/* src/wmf_ram.sv */
// Generic single-port-write, registered-read RAM.
module wmf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* src/wmf_div.sv */
// Unsigned restoring divider, one quotient bit per cycle.
module wmf_div #(
	parameter int W = 33
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] num,
	input  logic [W-1:0] den,
	output logic         done,
	output logic [W-1:0] quo
);

	localparam int CW = $clog2(W + 1);

	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  den_q;
	logic [W:0]    trial;
	logic          fits;

	assign trial = {rem_q, quo_q[W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CW'(W);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? W'(trial - {1'b0, den_q}) : trial[W-1:0];
			quo_q <= {quo_q[W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

/* src/wmf_checker.sv */
// Port-level checks of the windowed mean filter, bound to the top level.
module wmf_checker import wmf_pkg::*; #(
	parameter int SAMPLE_BITS = 16
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic signed [SAMPLE_BITS-1:0] mean,
	input logic [STAT_BITS-1:0]          status
);

	localparam logic [SAMPLE_BITS-1:0] MAX_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic [SAMPLE_BITS-1:0] MAX_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(mean) && $stable(status))
		else $error("output word changed while stalled");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == STAT_OK) || (status == STAT_DIV0) || (status == STAT_SAT))
		else $error("unknown status code");

	a_div0: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == STAT_DIV0) |-> (mean == '0))
		else $error("divide error with nonzero mean");

	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == STAT_SAT) |-> (mean == MAX_POS) || (mean == MAX_NEG))
		else $error("saturation flag without clamped mean");

endmodule

bind windowed_mean_filter_core wmf_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_wmf_checker (.*);

/* dv/tb_windowed_mean_filter_core.sv */
// Self-checking testbench of the windowed mean filter: directed table, then random phases.
`timescale 1ns / 100ps

module tb_windowed_mean_filter_core import wmf_pkg::*;;

	localparam int WMAX = 64;
	localparam int SBITS = 16;
	localparam int SETTLE_CYCLES = 3000;
	localparam int STUCK_LIMIT = 20000;
	localparam int ITEM_TARGET = 1600;

	typedef struct {
		logic signed [SBITS-1:0] m;
		logic [STAT_BITS-1:0] st;
	} mean_word_t;

	typedef enum {ROW_CFG, ROW_WORD} row_kind_t;

	typedef struct {
		row_kind_t kind;
		logic [CFG_INDEX_BITS-1:0] cidx;
		logic [CFG_DATA_BITS-1:0] cdata;
		logic op;
		logic signed [SBITS-1:0] smp;
		logic [WIDX_BITS-1:0] widx;
		logic [WVAL_BITS-1:0] wval;
		bit typed;
		logic signed [SBITS-1:0] em;
		logic [STAT_BITS-1:0] es;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic opcode = OP_PUSH;
	logic signed [SBITS-1:0] sample = '0;
	logic [WIDX_BITS-1:0] weight_index = '0;
	logic [WVAL_BITS-1:0] weight_value = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [SBITS-1:0] mean;
	logic [STAT_BITS-1:0] status;

	windowed_mean_filter_core dut (.*);

	// predictor state
	logic signed [SBITS-1:0] ring_q [WMAX];
	logic [WVAL_BITS-1:0] wtab [WMAX];
	int wr_ptr;
	int fill_cnt;
	logic [MODE_BITS-1:0] mode_r;
	logic [LEN_BITS-1:0] len_r;
	logic [ALPHA_BITS-1:0] alpha_r;

	mean_word_t means_due[$];
	stim_row_t rows[$];
	int errors = 0;
	int items_sent = 0;
	int stuck_cnt = 0;
	bit calm;

	assign calm = (items_sent >= 700 && items_sent < 900);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	task automatic report(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		errors++;
	endtask

	function automatic logic signed [SBITS-1:0] clamp(input longint v,
			inout logic [STAT_BITS-1:0] st);
		if (v > 32767) begin
			st = STAT_SAT;
			return 16'sh7fff;
		end
		if (v < -32768) begin
			st = STAT_SAT;
			return 16'sh8000;
		end
		return v[SBITS-1:0];
	endfunction

	task automatic predict_mean(input logic op, input logic signed [SBITS-1:0] smp,
			input logic [WIDX_BITS-1:0] wi, input logic [WVAL_BITS-1:0] wv,
			output bit has, output mean_word_t res);
		int len;
		longint x, acc, wsum, a, e;
		bit zero;
		has = 0;
		res.m = '0;
		res.st = STAT_OK;
		if (op == OP_WLOAD) begin
			wtab[wi] = wv;
			return;
		end
		ring_q[wr_ptr] = smp;
		wr_ptr = (wr_ptr + 1) % WMAX;
		if (fill_cnt < WMAX) fill_cnt++;
		len = (len_r == 0) ? 1 : (len_r > WMAX ? WMAX : len_r);
		if (fill_cnt < len) return;
		has = 1;
		acc = 0;
		wsum = 0;
		zero = 0;
		e = 0;
		a = (alpha_r > ALPHA_ONE) ? 256 : alpha_r;
		for (int k = 0; k < len; k++) begin
			x = ring_q[(wr_ptr + WMAX - len + k) % WMAX];
			case (mode_r)
				MODE_ARITH: acc += x;
				MODE_WEIGHTED: begin
					acc += x * longint'(wtab[k]);
					wsum += wtab[k];
				end
				MODE_HARMONIC: begin
					if (x == 0) zero = 1;
					else acc += longint'(16777216) / x;
				end
				default: e = (e * (256 - a) + a * x) / 256;
			endcase
			if (zero) break;
		end
		case (mode_r)
			MODE_ARITH: res.m = clamp(acc / len, res.st);
			MODE_WEIGHTED: begin
				if (wsum == 0) res.st = STAT_DIV0;
				else res.m = clamp(acc / wsum, res.st);
			end
			MODE_HARMONIC: begin
				if (zero || acc == 0) res.st = STAT_DIV0;
				else res.m = clamp((longint'(len) * 16777216) / acc, res.st);
			end
			default: res.m = clamp(e, res.st);
		endcase
	endtask

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			CFG_MODE: mode_r = val[MODE_BITS-1:0];
			CFG_LENGTH: len_r = val[LEN_BITS-1:0];
			CFG_ALPHA: alpha_r = val;
			default: ;
		endcase
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		cfg_valid <= 1'b0;
		@(posedge clk);
		while (means_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_word(input logic op, input logic signed [SBITS-1:0] smp,
			input logic [WIDX_BITS-1:0] wi, input logic [WVAL_BITS-1:0] wv,
			input bit typed, input mean_word_t typed_res);
		bit has;
		mean_word_t res;
		cfg_valid <= 1'b0;
		while (!calm && $urandom_range(99) < 13) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		sample <= smp;
		weight_index <= wi;
		weight_value <= wv;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
		predict_mean(op, smp, wi, wv, has, res);
		if (typed) means_due.push_back(typed_res);
		else if (has) means_due.push_back(res);
	endtask

	function automatic logic signed [SBITS-1:0] pick_sample();
		case ($urandom_range(9))
			0: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
			1, 2, 3: return $signed(16'($urandom_range(16))) - 16'sd8;
			default: return SBITS'($urandom);
		endcase
	endfunction

	function automatic void add_cfg(input logic [CFG_INDEX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] val);
		stim_row_t r;
		r = '{kind: ROW_CFG, cidx: idx, cdata: val, op: OP_PUSH, smp: 0, widx: 0,
			wval: 0, typed: 0, em: 0, es: STAT_OK};
		rows.push_back(r);
	endfunction

	function automatic void add_word(input logic op, input logic signed [SBITS-1:0] smp,
			input logic [WIDX_BITS-1:0] wi, input logic [WVAL_BITS-1:0] wv,
			input bit typed, input logic signed [SBITS-1:0] em,
			input logic [STAT_BITS-1:0] es);
		stim_row_t r;
		r = '{kind: ROW_WORD, cidx: 0, cdata: 0, op: op, smp: smp, widx: wi,
			wval: wv, typed: typed, em: em, es: es};
		rows.push_back(r);
	endfunction

	always @(posedge clk) begin
		out_stall <= calm ? 1'b0 : ($urandom_range(99) < 13);
	end

	always @(posedge clk) begin
		mean_word_t want;
		if (out_valid && !out_stall) begin
			if (means_due.size() == 0) begin
				report($sformatf("unexpected word mean=%0d status=%0d", mean, status));
			end else begin
				want = means_due.pop_front();
				if (mean !== want.m)
					report($sformatf("mean %0d, want %0d", mean, want.m));
				if (status !== want.st)
					report($sformatf("status %0d, want %0d", status, want.st));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			stuck_cnt <= 0;
		else
			stuck_cnt <= stuck_cnt + 1;
		if (stuck_cnt >= STUCK_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		bit prev_cfg;
		mean_word_t tw;
		int phase, n_items, eff_len;
		logic [MODE_BITS-1:0] pm;
		logic [LEN_BITS-1:0] pl;
		logic [ALPHA_BITS-1:0] pa;

		for (int i = 0; i < WMAX; i++) begin
			ring_q[i] = '0;
			wtab[i] = WEIGHT_RESET;
		end
		wr_ptr = 0;
		fill_cnt = 0;
		mode_r = MODE_ARITH;
		len_r = LENGTH_RESET;
		alpha_r = ALPHA_RESET;

		add_cfg(CFG_MODE, MODE_ARITH);
		add_cfg(CFG_LENGTH, 1);
		add_word(OP_PUSH, 16'sh7fff, 0, 0, 1, 16'sh7fff, STAT_OK);
		add_word(OP_PUSH, 16'sh8000, 0, 0, 1, 16'sh8000, STAT_OK);
		add_cfg(CFG_LENGTH, 0);
		add_word(OP_PUSH, 5, 0, 0, 1, 5, STAT_OK);
		add_cfg(CFG_MODE, MODE_HARMONIC);
		add_word(OP_PUSH, 0, 0, 0, 1, 0, STAT_DIV0);
		add_word(OP_PUSH, 256, 0, 0, 1, 256, STAT_OK);
		add_word(OP_PUSH, -1, 0, 0, 1, -1, STAT_OK);
		add_cfg(CFG_LENGTH, 2);
		add_word(OP_PUSH, 1, 0, 0, 0, 0, STAT_OK);
		add_word(OP_PUSH, -1, 0, 0, 1, 0, STAT_DIV0);
		add_word(OP_PUSH, 300, 0, 0, 0, 0, STAT_OK);
		add_word(OP_PUSH, -301, 0, 0, 1, 16'sh7fff, STAT_SAT);
		add_word(OP_PUSH, 301, 0, 0, 1, 0, STAT_DIV0);
		add_word(OP_PUSH, -300, 0, 0, 1, 16'sh8000, STAT_SAT);
		add_cfg(CFG_MODE, MODE_WEIGHTED);
		add_word(OP_WLOAD, 0, 0, 0, 0, 0, STAT_OK);
		add_word(OP_WLOAD, 0, 1, 0, 0, 0, STAT_OK);
		add_word(OP_PUSH, 9, 0, 0, 1, 0, STAT_DIV0);
		add_word(OP_WLOAD, 0, 63, 255, 0, 0, STAT_OK);
		add_word(OP_WLOAD, 0, 1, 3, 0, 0, STAT_OK);
		add_word(OP_PUSH, 100, 0, 0, 0, 0, STAT_OK);
		add_cfg(CFG_MODE, MODE_EXP);
		add_cfg(CFG_ALPHA, 511);
		add_word(OP_PUSH, 16'sh8000, 0, 0, 1, 16'sh8000, STAT_OK);
		add_cfg(CFG_ALPHA, 0);
		add_word(OP_PUSH, 7, 0, 0, 1, 0, STAT_OK);
		add_cfg(2'd3, 511);
		add_cfg(CFG_LENGTH, 127);
		add_word(OP_PUSH, 1234, 0, 0, 0, 0, STAT_OK);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		prev_cfg = 0;
		foreach (rows[i]) begin
			if (rows[i].kind == ROW_CFG) begin
				if (!prev_cfg) settle();
				write_reg(rows[i].cidx, rows[i].cdata);
				prev_cfg = 1;
			end else begin
				tw.m = rows[i].em;
				tw.st = rows[i].es;
				send_word(rows[i].op, rows[i].smp, rows[i].widx, rows[i].wval,
					rows[i].typed, tw);
				prev_cfg = 0;
			end
		end

		tw.m = '0;
		tw.st = STAT_OK;
		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			settle();
			pm = (phase == 0) ? MODE_ARITH : (phase == 1) ? MODE_EXP :
				MODE_BITS'($urandom_range(3));
			if (phase == 0) pl = 64;
			else if (phase == 1) pl = 127;
			else begin
				case ($urandom_range(9))
					0, 1, 2, 3, 4, 5: pl = LEN_BITS'($urandom_range(8));
					6, 7: pl = LEN_BITS'($urandom_range(24, 9));
					default: pl = LEN_BITS'($urandom_range(127, 25));
				endcase
			end
			pa = (phase == 1) ? ALPHA_ONE :
				($urandom_range(2) == 0) ? ALPHA_BITS'($urandom_range(511)) :
				ALPHA_BITS'($urandom_range(256));
			write_reg(CFG_MODE, pm);
			write_reg(CFG_LENGTH, pl);
			write_reg(CFG_ALPHA, pa);
			if ($urandom_range(3) == 0) write_reg(2'd3, CFG_DATA_BITS'($urandom));
			eff_len = (pl == 0) ? 1 : (pl > WMAX ? WMAX : pl);
			n_items = (pm == MODE_HARMONIC && eff_len > 24) ? 25 : 100;
			repeat (n_items) begin
				if ($urandom_range(9) == 0)
					send_word(OP_WLOAD, pick_sample(), WIDX_BITS'($urandom),
						($urandom_range(9) == 0) ? 8'd0 : 8'($urandom), 0, tw);
				else
					send_word(OP_PUSH, pick_sample(), WIDX_BITS'($urandom),
						WVAL_BITS'($urandom), 0, tw);
			end
			phase++;
		end

		settle();
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

/* files.f */
src/wmf_pkg.sv
src/wmf_ram.sv
src/wmf_div.sv
src/windowed_mean_filter_core.sv
src/wmf_checker.sv
dv/tb_windowed_mean_filter_core.sv
